/* hdl/tmatc_pkg.sv */
package tmatc_pkg;

    // default sizes of the sample path
    localparam int SAMPLE_BITS_DEF     = 12;
    localparam int COEFF_FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int NUM_LANES     = 3;
    localparam int TIME_BITS     = 32;
    localparam int THRESH_BITS   = 12;
    localparam int BLANK_BITS    = 32;
    localparam int COEFF_BITS    = 16;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;

    // register reset values
    localparam logic [THRESH_BITS-1:0] THRESH_RST = 12'd300;
    localparam logic [BLANK_BITS-1:0]  BLANK_RST  = 32'd100000;
    localparam logic [COEFF_BITS-1:0]  COEFF_RST  = 16'd7;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_BLANKING  = 2'd1,
        CFG_DC_COEFF  = 2'd2
    } cfg_index_t;

    // one sample set after the lanes have tested it
    typedef struct packed {
        logic                 valid;
        logic [NUM_LANES-1:0] hit;
        logic [TIME_BITS-1:0] time_us;
    } step_t;

endpackage

/* hdl/tmatc_in_if.sv */
interface tmatc_in_if #(
    parameter int SAMPLE_BITS = tmatc_pkg::SAMPLE_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [SAMPLE_BITS-1:0]         sample_a;
    logic [SAMPLE_BITS-1:0]         sample_b;
    logic [SAMPLE_BITS-1:0]         sample_c;
    logic [tmatc_pkg::TIME_BITS-1:0] time_us;

    modport source (output valid, sample_a, sample_b, sample_c, time_us, input ready);
    modport sink   (input valid, sample_a, sample_b, sample_c, time_us, output ready);
endinterface

/* hdl/tmatc_out_if.sv */
interface tmatc_out_if;
    logic                            valid;
    logic                            ready;
    logic [tmatc_pkg::TIME_BITS-1:0] delay_a;
    logic [tmatc_pkg::TIME_BITS-1:0] delay_b;
    logic [tmatc_pkg::TIME_BITS-1:0] delay_c;

    modport source (output valid, delay_a, delay_b, delay_c, input ready);
    modport sink   (input valid, delay_a, delay_b, delay_c, output ready);
endinterface

/* hdl/tmatc_lane.sv */
module tmatc_lane #(
    parameter int SAMPLE_BITS     = tmatc_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = tmatc_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [SAMPLE_BITS-1:0]             sample,
    input  logic [tmatc_pkg::COEFF_BITS-1:0]   dc_coeff,
    input  logic [tmatc_pkg::THRESH_BITS-1:0]  threshold,
    output logic                               hit
);
    localparam int F  = COEFF_FRAC_BITS;
    localparam int MW = SAMPLE_BITS + F;
    localparam int KW = (F + 1 > tmatc_pkg::COEFF_BITS) ? F + 1 : tmatc_pkg::COEFF_BITS;
    localparam int TW = ((SAMPLE_BITS > tmatc_pkg::THRESH_BITS) ?
                         SAMPLE_BITS : tmatc_pkg::THRESH_BITS) + F;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [KW-1:0]          coeff_ext;
    logic [KW-1:0]          one_ext;
    logic [KW-1:0]          k_full;
    logic [F:0]             k_sat;
    logic [F:0]             k_inv;
    logic [MW+F:0]          hold_prod;
    logic [MW:0]            new_prod;
    logic [MW:0]            mean_sum;
    logic [MW-1:0]          mean_next;
    logic [MW-1:0]          mean_reg;
    logic                   primed_reg;
    logic [SAMPLE_BITS-1:0] sample_s1_reg;
    logic [MW-1:0]          mean_s1_reg;
    logic [MW-1:0]          xs_s1;
    logic [MW-1:0]          mag;

    // weight of the new sample, saturated at one
    assign coeff_ext = KW'(dc_coeff);
    assign one_ext   = KW'(1) << F;
    assign k_full    = (coeff_ext > one_ext) ? one_ext : coeff_ext;
    assign k_sat     = k_full[F:0];
    assign k_inv     = ONE - k_sat;

    // exponential mean; the sample term has no fraction bits to drop
    assign hold_prod = (MW+F+1)'(mean_reg) * (MW+F+1)'(k_inv);
    assign new_prod  = (MW+1)'(sample) * (MW+1)'(k_sat);
    assign mean_sum  = hold_prod[MW+F:F] + new_prod;
    assign mean_next = primed_reg ? mean_sum[MW-1:0] : {sample, {F{1'b0}}};

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
        end
        else if (load)
        begin
            primed_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mean_reg      <= mean_next;
            sample_s1_reg <= sample;
            mean_s1_reg   <= mean_next;
        end
    end

    // threshold test on the registered sample and mean
    assign xs_s1 = {sample_s1_reg, {F{1'b0}}};
    assign mag   = (xs_s1 >= mean_s1_reg) ? (xs_s1 - mean_s1_reg) : (mean_s1_reg - xs_s1);
    assign hit   = TW'(mag) > TW'({threshold, {F{1'b0}}});

endmodule

/* hdl/tmatc_merge.sv */
module tmatc_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmatc_pkg::step_t                  step,
    input  logic [tmatc_pkg::BLANK_BITS-1:0]  blanking_time_us,
    output logic                              step_ready,
    tmatc_out_if.source                       result
);
    localparam int N  = tmatc_pkg::NUM_LANES;
    localparam int TB = tmatc_pkg::TIME_BITS;

    logic          step_take;
    logic [TB-1:0] elapsed;
    logic          in_window;
    logic [N-1:0]  cap_base;
    logic          started_base;
    logic [N-1:0]  cap_upd;
    logic [N-1:0]  new_hit;
    logic [TB-1:0] rel;
    logic          emit;

    logic [N-1:0]  cap_reg, cap_next;
    logic          started_reg, started_next;
    logic [TB-1:0] start_reg, start_next;
    logic          blank_reg, blank_next;
    logic [TB-1:0] blank_start_reg, blank_start_next;
    logic [TB-1:0] delay_reg [N];
    logic [TB-1:0] delay_next [N];
    logic          out_valid_reg, out_valid_next;

    // a step moves on once the result slot is free or being emptied
    assign step_ready = !out_valid_reg || result.ready;
    assign step_take  = step.valid && step_ready;

    // blanking window and rearm
    assign elapsed      = step.time_us - blank_start_reg;
    assign in_window    = blank_reg && (elapsed < blanking_time_us);
    assign cap_base     = blank_reg ? '0 : cap_reg;
    assign started_base = blank_reg ? 1'b0 : started_reg;

    // new crossings, all timed against the event start
    assign new_hit = step.hit & ~cap_base;
    assign cap_upd = cap_base | step.hit;
    assign rel     = started_base ? (step.time_us - start_reg) : '0;
    assign emit    = step_take && !in_window && (&cap_upd);

    always_comb
    begin
        cap_next         = cap_reg;
        started_next     = started_reg;
        start_next       = start_reg;
        blank_next       = blank_reg;
        blank_start_next = blank_start_reg;
        for (int i = 0; i < N; i++)
        begin
            delay_next[i] = delay_reg[i];
        end
        if (step_take && !in_window)
        begin
            cap_next     = cap_upd;
            started_next = started_base || (|step.hit);
            if (!started_base && (|step.hit))
            begin
                start_next = step.time_us;
            end
            for (int i = 0; i < N; i++)
            begin
                if (new_hit[i])
                begin
                    delay_next[i] = rel;
                end
            end
            blank_next = &cap_upd;
            if (&cap_upd)
            begin
                blank_start_next = step.time_us;
            end
        end
    end

    // result slot
    always_comb
    begin
        priority if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= '0;
            started_reg   <= 1'b0;
            blank_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            started_reg   <= started_next;
            blank_reg     <= blank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg       <= start_next;
        blank_start_reg <= blank_start_next;
        for (int i = 0; i < N; i++)
        begin
            delay_reg[i] <= delay_next[i];
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.delay_a = delay_reg[0];
    assign result.delay_b = delay_reg[1];
    assign result.delay_c = delay_reg[2];

`ifndef SYNTHESIS
    // a fresh result always opens a blanking window
    a_emit_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> blank_reg)
        else $error("result emitted without blanking");

    // a complete capture only exists while blanking
    a_full_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        (&cap_reg) |-> blank_reg)
        else $error("all channels captured outside blanking");

    // any capture implies an event start
    a_cap_started: assert property (@(posedge clk) disable iff (!rst_n)
        (|cap_reg) |-> started_reg)
        else $error("capture without event start");

    // items inside the window leave the capture untouched
    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_take && in_window) |=> ($stable(cap_reg) && $stable(blank_reg)))
        else $error("capture changed during blanking");
`endif

endmodule

/* hdl/three_mic_arrival_time_capture.sv */
// Three-channel acoustic arrival-time capture. Each item is one sample from
// each of three microphones plus a microsecond timestamp. Every channel runs
// its own DC tracker lane (exponential mean, Q.16 fraction, primed by the
// first sample) and flags a crossing when the DC-free magnitude exceeds the
// threshold; a merge stage times each channel's first crossing against the
// earliest one and, once all three have crossed, emits one result item with
// the three delays and then ignores crossings for blanking_time_us. The block
// takes one item per clock: the lane mean update (two multiplies and an add
// per lane) is a register feedback loop. Input stalls only while a finished
// result is still unclaimed and the item behind it already waits in the lane
// stage. Write configuration with cfg_wr_en/cfg_index/cfg_data only while no
// item is in flight; the block itself does not enforce it.
module three_mic_arrival_time_capture #(
    parameter int SAMPLE_BITS     = tmatc_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = tmatc_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tmatc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tmatc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    tmatc_in_if.sink                             samples,
    tmatc_out_if.source                          result
);
    localparam int N = tmatc_pkg::NUM_LANES;

    logic [tmatc_pkg::THRESH_BITS-1:0] threshold_reg;
    logic [tmatc_pkg::BLANK_BITS-1:0]  blanking_reg;
    logic [tmatc_pkg::COEFF_BITS-1:0]  dc_coeff_reg;

    logic                             accept;
    logic                             step_ready;
    logic                             s1_valid_reg;
    logic [tmatc_pkg::TIME_BITS-1:0]  time_s1_reg;
    logic [SAMPLE_BITS-1:0]           lane_sample [N];
    logic [N-1:0]                     lane_hit;
    tmatc_pkg::step_t                 step;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tmatc_pkg::THRESH_RST;
            blanking_reg  <= tmatc_pkg::BLANK_RST;
            dc_coeff_reg  <= tmatc_pkg::COEFF_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tmatc_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[tmatc_pkg::THRESH_BITS-1:0];
                tmatc_pkg::CFG_BLANKING:  blanking_reg  <= cfg_data[tmatc_pkg::BLANK_BITS-1:0];
                tmatc_pkg::CFG_DC_COEFF:  dc_coeff_reg  <= cfg_data[tmatc_pkg::COEFF_BITS-1:0];
                default:                  ;
            endcase
        end
    end

    // input handshake; the lane stage holds one item
    assign samples.ready = !s1_valid_reg || step_ready;
    assign accept        = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_s1_reg <= samples.time_us;
        end
    end

    // one DC tracker lane per microphone
    assign lane_sample[0] = samples.sample_a;
    assign lane_sample[1] = samples.sample_b;
    assign lane_sample[2] = samples.sample_c;

    for (genvar g = 0; g < N; g++)
    begin : g_lane
        tmatc_lane #(
            .SAMPLE_BITS     (SAMPLE_BITS),
            .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (accept),
            .sample    (lane_sample[g]),
            .dc_coeff  (dc_coeff_reg),
            .threshold (threshold_reg),
            .hit       (lane_hit[g])
        );
    end

    // crossings and timestamp on to the merge stage
    assign step.valid   = s1_valid_reg;
    assign step.hit     = lane_hit;
    assign step.time_us = time_s1_reg;

    tmatc_merge u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .blanking_time_us (blanking_reg),
        .step_ready       (step_ready),
        .result           (result)
    );

endmodule
